[design/circular_lens_mask_compositor_core_macros.svh]
// assertion macros for the circular lens mask compositor core
// no dependencies; included by files that carry concurrent assertions
`ifndef CIRCULAR_LENS_MASK_COMPOSITOR_CORE_MACROS_SVH
`define CIRCULAR_LENS_MASK_COMPOSITOR_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define CLMC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define CLMC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define CLMC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg)
`define CLMC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

[design/clmc_pkg.sv]
// shared constants, types and helper function of the lens mask compositor
// no dependencies; imported by every design and test file except the macro header
package clmc_pkg;

	localparam int MAX_DIAMETER = 1024;

	localparam int POS_W      = 10;
	localparam int DIAM_W     = 10;
	localparam int BORDER_W   = 5;
	localparam int CH_W       = 8;
	localparam int NUM_CH     = 3;
	localparam int PROD_W     = 2 * CH_W;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 10;

	localparam logic [CFG_IDX_W-1:0] REG_DIAMETER     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BORDER_WIDTH = 2'd1;

	localparam logic [DIAM_W-1:0]   DIAMETER_RESET     = 10'd300;
	localparam logic [BORDER_W-1:0] BORDER_WIDTH_RESET = 5'd4;

	localparam int CH_RED   = 0;
	localparam int CH_GREEN = 1;
	localparam int CH_BLUE  = 2;

	// u = 2x+1-d and k = d-2b as signed values
	localparam int COORD_W = POS_W + 2;
	localparam int SQ_W    = 2 * POS_W + 2;
	localparam int SUM_W   = SQ_W + 1;
	// inside the fading band S < (k+1)^2 <= 2^(2*POS_W)
	localparam int BAND_W  = 2 * POS_W;
	localparam int FRAC_W  = 8;
	localparam int RAD_W   = BAND_W + 2 * FRAC_W;
	localparam int ROOT_W  = RAD_W / 2;
	localparam int REM_W   = ROOT_W + 2;
	localparam int NUM_W   = ROOT_W + 2;
	localparam int FADE_SHIFT = 9;

	localparam logic [CH_W-1:0] ALPHA_MAX = 8'hFF;

	localparam int GEOM_STAGES  = 3;
	localparam int SQRT_STAGES  = ROOT_W / 2;
	localparam int BLEND_STAGES = 6;
	localparam int PIPE_DEPTH   = GEOM_STAGES + SQRT_STAGES + BLEND_STAGES;

	typedef logic [NUM_CH-1:0][CH_W-1:0]   color_t;
	typedef logic [NUM_CH-1:0][PROD_W-1:0] prod_t;

	typedef struct packed {
		color_t          cap;
		logic [CH_W-1:0] ovl_alpha;
		color_t          ovl;
	} pass_t;

	typedef struct packed {
		pass_t          pass;
		logic           kneg;
		logic           full;
		logic           zero;
		logic [POS_W:0] kp1;
	} geom_t;

	// floor(x/255), exact for x up to 255*256-1
	function automatic logic [CH_W-1:0] div255(input logic [PROD_W-1:0] x);
		logic [PROD_W:0] t;
		t = {1'b0, x} + (PROD_W + 1)'(x >> CH_W) + (PROD_W + 1)'(1);
		return t[PROD_W-1:CH_W];
	endfunction

endpackage

[design/clmc_if.sv]
// handshake channels of the lens mask compositor: pixel in, result out, config
// depends on clmc_pkg
interface clmc_pix_in_if import clmc_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [POS_W-1:0] pos_x;
	logic [POS_W-1:0] pos_y;
	logic [CH_W-1:0]  cap_red;
	logic [CH_W-1:0]  cap_green;
	logic [CH_W-1:0]  cap_blue;
	logic [CH_W-1:0]  ovl_alpha;
	logic [CH_W-1:0]  ovl_red;
	logic [CH_W-1:0]  ovl_green;
	logic [CH_W-1:0]  ovl_blue;

	modport source(output valid, pos_x, pos_y, cap_red, cap_green, cap_blue,
		ovl_alpha, ovl_red, ovl_green, ovl_blue, input ready);
	modport sink(input valid, pos_x, pos_y, cap_red, cap_green, cap_blue,
		ovl_alpha, ovl_red, ovl_green, ovl_blue, output ready);
endinterface

interface clmc_pix_out_if import clmc_pkg::*; ();
	logic            valid;
	logic            ready;
	logic [CH_W-1:0] res_alpha;
	logic [CH_W-1:0] res_red;
	logic [CH_W-1:0] res_green;
	logic [CH_W-1:0] res_blue;

	modport source(output valid, res_alpha, res_red, res_green, res_blue, input ready);
	modport sink(input valid, res_alpha, res_red, res_green, res_blue, output ready);
endinterface

interface clmc_cfg_if import clmc_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

[design/circular_lens_mask_compositor_core.sv]
// pipeline: a pixel request, once accepted, passes through 3 geometry stages,
// 9 square-root stages and 6 blend stages before its result is valid
// throughput: one pixel per clock unless the result side stalls; a stall holds
// stages only as far back as the pipeline is full, and the other stages move on
// reset: diameter 300, border width 4, all pipeline valid bits cleared
`include "circular_lens_mask_compositor_core_macros.svh"
module circular_lens_mask_compositor_core import clmc_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	clmc_cfg_if.sink        cfg,
	clmc_pix_in_if.sink     pixel,
	clmc_pix_out_if.source  result
);

	logic [DIAM_W-1:0]   diameter_q;
	logic [BORDER_W-1:0] border_width_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			diameter_q     <= DIAMETER_RESET;
			border_width_q <= BORDER_WIDTH_RESET;
		end else if (cfg.valid && cfg.ready) begin
			// unknown indexes are dropped
			if (cfg.index == REG_DIAMETER) begin
				diameter_q <= cfg.data[DIAM_W-1:0];
			end
			if (cfg.index == REG_BORDER_WIDTH) begin
				border_width_q <= cfg.data[BORDER_W-1:0];
			end
		end
	end

	logic              geom_valid, geom_ready;
	logic [RAD_W-1:0]  geom_rad;
	geom_t             geom_tag;
	logic              sq_valid, sq_ready;
	logic [ROOT_W-1:0] sq_root;
	geom_t             sq_tag;

	clmc_geom u_geom (
		.clk          (clk),
		.arst_n       (arst_n),
		.pixel        (pixel),
		.diameter     (diameter_q),
		.border_width (border_width_q),
		.out_valid    (geom_valid),
		.out_ready    (geom_ready),
		.out_rad      (geom_rad),
		.out_tag      (geom_tag)
	);

	clmc_isqrt u_isqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (geom_valid),
		.in_ready  (geom_ready),
		.in_rad    (geom_rad),
		.in_tag    (geom_tag),
		.out_valid (sq_valid),
		.out_ready (sq_ready),
		.out_root  (sq_root),
		.out_tag   (sq_tag)
	);

	clmc_blend u_blend (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (sq_valid),
		.in_ready (sq_ready),
		.in_root  (sq_root),
		.in_tag   (sq_tag),
		.result   (result)
	);

	// requests in flight, for the checks below
	localparam int CNT_W = $clog2(PIPE_DEPTH + 1);

	logic             acc_in, acc_out;
	logic [CNT_W-1:0] inflight_q;

	assign acc_in  = pixel.valid && pixel.ready;
	assign acc_out = result.valid && result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else if (acc_in && !acc_out) begin
			inflight_q <= inflight_q + CNT_W'(1);
		end else if (acc_out && !acc_in) begin
			inflight_q <= inflight_q - CNT_W'(1);
		end
	end

	`CLMC_ASSERT_NOW(a_empty_no_result, clk, arst_n, inflight_q == '0, !result.valid, "result without pending request")
	`CLMC_ASSERT_NOW(a_full_stalls_input, clk, arst_n, (inflight_q == CNT_W'(PIPE_DEPTH)) && !result.ready, !pixel.ready, "input taken into a full stalled pipeline")
	`CLMC_ASSERT_NEXT(a_accept_counted, clk, arst_n, acc_in && !acc_out, inflight_q != '0, "accepted request not tracked")
	`CLMC_ASSERT_NOW(a_zero_alpha_black, clk, arst_n, result.valid && (result.res_alpha == '0), (result.res_red == '0) && (result.res_green == '0) && (result.res_blue == '0), "color under zero alpha")

endmodule

[design/clmc_geom.sv]
// geometry front end: lens coordinates, squared radius and band classification
// three pipeline stages; depends on clmc_pkg and clmc_pix_in_if
module clmc_geom import clmc_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	clmc_pix_in_if.sink         pixel,
	input  logic [DIAM_W-1:0]   diameter,
	input  logic [BORDER_W-1:0] border_width,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [RAD_W-1:0]    out_rad,
	output geom_t               out_tag
);

	logic en1, en2, en3;
	logic vld_s1, vld_s2, vld_s3;

	assign en3 = !vld_s3 || out_ready;
	assign en2 = !vld_s2 || en3;
	assign en1 = !vld_s1 || en2;
	assign pixel.ready = en1;

	// stage 1: centered coordinates and inner radius
	logic [DIAM_W-1:0]         d_eff;
	logic signed [COORD_W-1:0] cu_c, cv_c, k_c;
	pass_t                     pass_c;

	always_comb begin
		d_eff = (int'(diameter) > MAX_DIAMETER) ? DIAM_W'(MAX_DIAMETER) : diameter;
		cu_c = signed'({1'b0, pixel.pos_x, 1'b1}) - signed'(COORD_W'(d_eff));
		cv_c = signed'({1'b0, pixel.pos_y, 1'b1}) - signed'(COORD_W'(d_eff));
		k_c  = signed'(COORD_W'(d_eff)) - signed'(COORD_W'({border_width, 1'b0}));
		pass_c.cap[CH_RED]   = pixel.cap_red;
		pass_c.cap[CH_GREEN] = pixel.cap_green;
		pass_c.cap[CH_BLUE]  = pixel.cap_blue;
		pass_c.ovl_alpha     = pixel.ovl_alpha;
		pass_c.ovl[CH_RED]   = pixel.ovl_red;
		pass_c.ovl[CH_GREEN] = pixel.ovl_green;
		pass_c.ovl[CH_BLUE]  = pixel.ovl_blue;
	end

	logic signed [COORD_W-1:0] cu_s1, cv_s1, k_s1;
	pass_t                     pass_s1;

	// stage 2: squares of the coordinates and of the band edges
	logic signed [COORD_W-1:0]   km1_c, kp1_c;
	logic signed [2*COORD_W-1:0] pu_c, pv_c, pkm_c, pkp_c;

	always_comb begin
		km1_c = k_s1 - COORD_W'(signed'(2'sd1));
		kp1_c = k_s1 + COORD_W'(signed'(2'sd1));
		pu_c  = cu_s1 * cu_s1;
		pv_c  = cv_s1 * cv_s1;
		pkm_c = km1_c * km1_c;
		pkp_c = kp1_c * kp1_c;
	end

	logic [SQ_W-1:0] squ_s2, sqv_s2, km2_s2, kp2_s2;
	logic            kneg_s2, kge1_s2;
	logic [POS_W:0]  kp1_s2;
	pass_t           pass_s2;

	// stage 3: squared radius against the band edges
	logic [SUM_W-1:0] sum_c;
	geom_t            tag_c;

	always_comb begin
		sum_c      = {1'b0, squ_s2} + {1'b0, sqv_s2};
		tag_c.pass = pass_s2;
		tag_c.kneg = kneg_s2;
		tag_c.full = kge1_s2 && (sum_c <= {1'b0, km2_s2});
		tag_c.zero = sum_c >= {1'b0, kp2_s2};
		tag_c.kp1  = kp1_s2;
	end

	logic [RAD_W-1:0] rad_s3;
	geom_t            tag_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (en1) vld_s1 <= pixel.valid;
			if (en2) vld_s2 <= vld_s1;
			if (en3) vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && pixel.valid) begin
			cu_s1   <= cu_c;
			cv_s1   <= cv_c;
			k_s1    <= k_c;
			pass_s1 <= pass_c;
		end
		if (en2 && vld_s1) begin
			squ_s2  <= pu_c[SQ_W-1:0];
			sqv_s2  <= pv_c[SQ_W-1:0];
			km2_s2  <= pkm_c[SQ_W-1:0];
			kp2_s2  <= pkp_c[SQ_W-1:0];
			kneg_s2 <= kp1_c[COORD_W-1] || (kp1_c == '0);
			kge1_s2 <= !km1_c[COORD_W-1];
			kp1_s2  <= kp1_c[POS_W:0];
			pass_s2 <= pass_s1;
		end
		if (en3 && vld_s2) begin
			// only the fading band uses the root, where S fits BAND_W bits
			rad_s3 <= {sum_c[BAND_W-1:0], {(2 * FRAC_W){1'b0}}};
			tag_s3 <= tag_c;
		end
	end

	assign out_valid = vld_s3;
	assign out_rad   = rad_s3;
	assign out_tag   = tag_s3;

endmodule

[design/clmc_isqrt.sv]
// pipelined floor square root, two result bits per stage, tag carried alongside
// depends on clmc_pkg
module clmc_isqrt import clmc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [RAD_W-1:0]  in_rad,
	input  geom_t             in_tag,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [ROOT_W-1:0] out_root,
	output geom_t             out_tag
);

	localparam int NS = SQRT_STAGES;

	typedef struct packed {
		logic [REM_W-1:0]  rem;
		logic [ROOT_W-1:0] root;
	} sq_t;

	// one restoring step: bring down a pair of radicand bits
	function automatic sq_t sq_step(input sq_t cur, input logic [1:0] pair);
		logic [REM_W+1:0] r2;
		logic [REM_W+1:0] trial;
		sq_t              nxt;
		r2    = {cur.rem, pair};
		trial = (REM_W + 2)'({cur.root, 2'b01});
		if (r2 >= trial) begin
			nxt.rem  = REM_W'(r2 - trial);
			nxt.root = {cur.root[ROOT_W-2:0], 1'b1};
		end else begin
			nxt.rem  = r2[REM_W-1:0];
			nxt.root = {cur.root[ROOT_W-2:0], 1'b0};
		end
		return nxt;
	endfunction

	logic             vld_s [NS];
	logic             en    [NS];
	sq_t              st_s  [NS];
	logic [RAD_W-1:0] rad_s [NS];
	geom_t            tag_s [NS];

	for (genvar i = 0; i < NS; i++) begin : g_stage
		sq_t              src_st, step_a, step_b;
		logic [RAD_W-1:0] src_rad;
		geom_t            src_tag;
		logic             src_vld;

		if (i == 0) begin : g_first
			assign src_st  = '0;
			assign src_rad = in_rad;
			assign src_tag = in_tag;
			assign src_vld = in_valid;
		end else begin : g_next
			assign src_st  = st_s[i-1];
			assign src_rad = rad_s[i-1];
			assign src_tag = tag_s[i-1];
			assign src_vld = vld_s[i-1];
		end

		if (i == NS - 1) begin : g_last_en
			assign en[i] = !vld_s[i] || out_ready;
		end else begin : g_mid_en
			assign en[i] = !vld_s[i] || en[i+1];
		end

		always_comb begin
			step_a = sq_step(src_st, src_rad[RAD_W-1 -: 2]);
			step_b = sq_step(step_a, src_rad[RAD_W-3 -: 2]);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else if (en[i]) begin
				vld_s[i] <= src_vld;
			end
		end

		always_ff @(posedge clk) begin
			if (en[i] && src_vld) begin
				st_s[i]  <= step_b;
				rad_s[i] <= src_rad << 4;
				tag_s[i] <= src_tag;
			end
		end
	end

	assign in_ready  = en[0];
	assign out_valid = vld_s[NS-1];
	assign out_root  = st_s[NS-1].root;
	assign out_tag   = tag_s[NS-1];

endmodule

[design/clmc_blend.sv]
// mask alpha from the root, premultiply and overlay compositing, six stages
// depends on clmc_pkg and clmc_pix_out_if
module clmc_blend import clmc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [ROOT_W-1:0] in_root,
	input  geom_t             in_tag,
	clmc_pix_out_if.source    result
);

	logic en1, en2, en3, en4, en5, en6;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;

	assign en6 = !vld_s6 || result.ready;
	assign en5 = !vld_s5 || en6;
	assign en4 = !vld_s4 || en5;
	assign en3 = !vld_s3 || en4;
	assign en2 = !vld_s2 || en3;
	assign en1 = !vld_s1 || en2;
	assign in_ready = en1;

	// stage 1: mask alpha
	logic [NUM_W-1:0]      num_c;
	logic [NUM_W+CH_W-1:0] scaled_c;
	logic [CH_W-1:0]       m_c;

	always_comb begin
		num_c    = (NUM_W'(in_tag.kp1) << FRAC_W) - NUM_W'(in_root);
		scaled_c = {num_c, {CH_W{1'b0}}} - (NUM_W + CH_W)'(num_c);
		priority if (in_tag.kneg) begin
			m_c = '0;
		end else if (in_tag.full) begin
			m_c = ALPHA_MAX;
		end else if (in_tag.zero) begin
			m_c = '0;
		end else begin
			m_c = scaled_c[FADE_SHIFT +: CH_W];
		end
	end

	logic [CH_W-1:0] m_s1, m_s2, m_s3;
	pass_t           pass_s1;
	prod_t           pc_s2;
	logic [CH_W-1:0] sa_s2, sa_s3, sa_s4, sa_s5;
	color_t          ovl_s2, ovl_s3;
	color_t          dc_s3;
	prod_t           po_s4, pd_s4, tc_s5;
	logic [PROD_W-1:0] pa_s4, pa_s5;
	logic            mz_s4, mz_s5;
	logic [CH_W-1:0] ra_s6;
	color_t          rc_s6;

	logic [CH_W-1:0] inv_c;
	assign inv_c = ALPHA_MAX - sa_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			if (en1) vld_s1 <= in_valid;
			if (en2) vld_s2 <= vld_s1;
			if (en3) vld_s3 <= vld_s2;
			if (en4) vld_s4 <= vld_s3;
			if (en5) vld_s5 <= vld_s4;
			if (en6) vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && in_valid) begin
			m_s1    <= m_c;
			pass_s1 <= in_tag.pass;
		end
		// stage 2: captured color times mask
		if (en2 && vld_s1) begin
			for (int c = 0; c < NUM_CH; c++) begin
				pc_s2[c] <= PROD_W'(pass_s1.cap[c]) * PROD_W'(m_s1);
			end
			m_s2   <= m_s1;
			sa_s2  <= pass_s1.ovl_alpha;
			ovl_s2 <= pass_s1.ovl;
		end
		// stage 3: premultiplied destination
		if (en3 && vld_s2) begin
			for (int c = 0; c < NUM_CH; c++) begin
				dc_s3[c] <= div255(pc_s2[c]);
			end
			m_s3   <= m_s2;
			sa_s3  <= sa_s2;
			ovl_s3 <= ovl_s2;
		end
		// stage 4: over-operator products
		if (en4 && vld_s3) begin
			for (int c = 0; c < NUM_CH; c++) begin
				po_s4[c] <= PROD_W'(ovl_s3[c]) * PROD_W'(sa_s3);
				pd_s4[c] <= PROD_W'(dc_s3[c]) * PROD_W'(inv_c);
			end
			pa_s4 <= PROD_W'(m_s3) * PROD_W'(inv_c);
			sa_s4 <= sa_s3;
			mz_s4 <= (m_s3 == '0);
		end
		// stage 5: sums stay below 255*256
		if (en5 && vld_s4) begin
			for (int c = 0; c < NUM_CH; c++) begin
				tc_s5[c] <= po_s4[c] + pd_s4[c];
			end
			pa_s5 <= pa_s4;
			sa_s5 <= sa_s4;
			mz_s5 <= mz_s4;
		end
		// stage 6: output register, zero mask clears the whole pixel
		if (en6 && vld_s5) begin
			if (mz_s5) begin
				ra_s6 <= '0;
				rc_s6 <= '0;
			end else begin
				ra_s6 <= sa_s5 + div255(pa_s5);
				for (int c = 0; c < NUM_CH; c++) begin
					rc_s6[c] <= div255(tc_s5[c]);
				end
			end
		end
	end

	assign result.valid     = vld_s6;
	assign result.res_alpha = ra_s6;
	assign result.res_red   = rc_s6[CH_RED];
	assign result.res_green = rc_s6[CH_GREEN];
	assign result.res_blue  = rc_s6[CH_BLUE];

endmodule

[test/tb_circular_lens_mask_compositor_core.sv]
// self-checking testbench of the circular lens mask compositor core
// predicts the antialiased circle mask and the over blend per pixel request
// depends on clmc_pkg and the interfaces in clmc_if.sv
module tb_circular_lens_mask_compositor_core import clmc_pkg::*; ();

	localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;
	localparam int LONG_HOLD_CYCLES = 300;

	typedef struct packed {
		logic [POS_W-1:0] pos_x;
		logic [POS_W-1:0] pos_y;
		logic [CH_W-1:0]  cap_red;
		logic [CH_W-1:0]  cap_green;
		logic [CH_W-1:0]  cap_blue;
		logic [CH_W-1:0]  ovl_alpha;
		logic [CH_W-1:0]  ovl_red;
		logic [CH_W-1:0]  ovl_green;
		logic [CH_W-1:0]  ovl_blue;
	} px_req_t;

	typedef struct packed {
		logic [CH_W-1:0] res_alpha;
		logic [CH_W-1:0] res_red;
		logic [CH_W-1:0] res_green;
		logic [CH_W-1:0] res_blue;
	} px_result_t;

	logic clk = 1'b0;
	logic arst_n;

	clmc_cfg_if     cfg_if();
	clmc_pix_in_if  pix_if();
	clmc_pix_out_if res_if();

	circular_lens_mask_compositor_core i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_if),
		.pixel  (pix_if),
		.result (res_if)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin
		#2_000_000;
		$display("Mismatches found");
		$finish;
	end

	// shadow copy of the two lens registers
	logic [DIAM_W-1:0]   lens_diam;
	logic [BORDER_W-1:0] lens_border;

	px_result_t blend_expect_q[$];
	int  mismatch_cnt = 0;
	bit  src_idle_on = 1'b1;
	bit  sink_idle_on = 1'b1;
	bit  sink_hold_req = 1'b0;
	int  sink_stall_left = 0;

	function automatic longint unsigned floor_root(input longint unsigned n);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n)
			b >>= 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n = n - (r + b);
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic logic [CH_W-1:0] coverage_alpha(input logic [POS_W-1:0] x,
			input logic [POS_W-1:0] y);
		longint d, u, v, s, k, num;
		d = longint'(lens_diam);
		u = 2 * longint'(x) + 1 - d;
		v = 2 * longint'(y) + 1 - d;
		s = u * u + v * v;
		k = d - 2 * longint'(lens_border);
		if (k + 1 <= 0)
			return '0;
		if (k - 1 >= 0 && s <= (k - 1) * (k - 1))
			return ALPHA_MAX;
		if (s >= (k + 1) * (k + 1))
			return '0;
		num = (k + 1) * 256 - longint'(floor_root(longint'(s) << 16));
		return CH_W'((num * 255) / 512);
	endfunction

	// premultiply by the mask, then the overlay over it; opaque and clear overlay fall out
	function automatic logic [CH_W-1:0] over_channel(input logic [CH_W-1:0] ovl_c,
			input logic [CH_W-1:0] cap_c, input logic [CH_W-1:0] m,
			input logic [CH_W-1:0] sa);
		int dc;
		dc = int'(cap_c) * int'(m) / int'(ALPHA_MAX);
		return CH_W'((int'(ovl_c) * int'(sa) + dc * (int'(ALPHA_MAX) - int'(sa)))
			/ int'(ALPHA_MAX));
	endfunction

	function automatic px_result_t predict_blend(input px_req_t p);
		px_result_t r;
		logic [CH_W-1:0] m;
		m = coverage_alpha(p.pos_x, p.pos_y);
		if (m == '0)
			return '0;
		r.res_alpha = CH_W'(int'(p.ovl_alpha)
			+ int'(m) * (int'(ALPHA_MAX) - int'(p.ovl_alpha)) / int'(ALPHA_MAX));
		r.res_red   = over_channel(p.ovl_red, p.cap_red, m, p.ovl_alpha);
		r.res_green = over_channel(p.ovl_green, p.cap_green, m, p.ovl_alpha);
		r.res_blue  = over_channel(p.ovl_blue, p.cap_blue, m, p.ovl_alpha);
		return r;
	endfunction

	function automatic logic [POS_W-1:0] pos_clip(input int w);
		if (w < 0)
			return '0;
		if (w > (1 << POS_W) - 1)
			return '1;
		return POS_W'(w);
	endfunction

	function automatic px_req_t pixel_at(input int x, input int y,
			input logic [3*CH_W-1:0] cap, input logic [CH_W-1:0] oa,
			input logic [3*CH_W-1:0] ovl);
		px_req_t p;
		p.pos_x = POS_W'(x);
		p.pos_y = POS_W'(y);
		{p.cap_red, p.cap_green, p.cap_blue} = cap;
		p.ovl_alpha = oa;
		{p.ovl_red, p.ovl_green, p.ovl_blue} = ovl;
		return p;
	endfunction

	function automatic px_req_t random_pixel();
		px_req_t p;
		int d, k, u, v, w, sel;
		d = int'(lens_diam);
		k = d - 2 * int'(lens_border);
		sel = $urandom_range(0, 9);
		if (sel == 0) begin
			p.pos_x = POS_W'($urandom);
			p.pos_y = POS_W'($urandom);
		end else if (sel <= 6 && k >= 1) begin
			// land close to the antialiased edge of the circle
			v = int'($urandom_range(0, 2 * k)) - k;
			u = int'(floor_root(longint'(k * k - v * v))) + int'($urandom_range(0, 6)) - 3;
			if ($urandom_range(0, 1))
				u = -u;
			if ($urandom_range(0, 1)) begin
				w = u;
				u = v;
				v = w;
			end
			p.pos_x = pos_clip((u + d - 1 < 0) ? -1 : (u + d - 1) / 2);
			p.pos_y = pos_clip((v + d - 1 < 0) ? -1 : (v + d - 1) / 2);
		end else begin
			p.pos_x = pos_clip($urandom_range(0, (d > 0) ? d - 1 : 0));
			p.pos_y = pos_clip($urandom_range(0, (d > 0) ? d - 1 : 0));
		end
		p.cap_red   = CH_W'($urandom);
		p.cap_green = CH_W'($urandom);
		p.cap_blue  = CH_W'($urandom);
		case ($urandom_range(0, 3))
			0: p.ovl_alpha = '0;
			1: p.ovl_alpha = ALPHA_MAX;
			default: p.ovl_alpha = CH_W'($urandom);
		endcase
		p.ovl_red   = CH_W'($urandom);
		p.ovl_green = CH_W'($urandom);
		p.ovl_blue  = CH_W'($urandom);
		return p;
	endfunction

	task automatic send_pixel(input px_req_t p);
		if (src_idle_on && $urandom_range(0, 5) == 0) begin
			pix_if.valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		pix_if.valid     <= 1'b1;
		pix_if.pos_x     <= p.pos_x;
		pix_if.pos_y     <= p.pos_y;
		pix_if.cap_red   <= p.cap_red;
		pix_if.cap_green <= p.cap_green;
		pix_if.cap_blue  <= p.cap_blue;
		pix_if.ovl_alpha <= p.ovl_alpha;
		pix_if.ovl_red   <= p.ovl_red;
		pix_if.ovl_green <= p.ovl_green;
		pix_if.ovl_blue  <= p.ovl_blue;
		do @(posedge clk); while (!pix_if.ready);
		blend_expect_q.push_back(predict_blend(p));
	endtask

	task automatic wait_drained();
		pix_if.valid <= 1'b0;
		while (blend_expect_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] value);
		wait_drained();
		repeat (PIPE_DEPTH + 4) @(posedge clk);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data  <= value;
		do @(posedge clk); while (!cfg_if.ready);
		cfg_if.valid <= 1'b0;
		case (idx)
			REG_DIAMETER:     lens_diam = value;
			REG_BORDER_WIDTH: lens_border = value[BORDER_W-1:0];
			default: ;
		endcase
	endtask

	task automatic set_lens(input int d, input int b);
		write_reg(REG_DIAMETER, CFG_DATA_W'(d));
		write_reg(REG_BORDER_WIDTH, CFG_DATA_W'(b));
	endtask

	// reset geometry: diameter 300, border 4, so the edge sits at u = 291..293
	task automatic test_default_geometry();
		send_pixel(pixel_at(149, 149, 24'hFF0080, 8'h00, 24'h123456));
		send_pixel(pixel_at(149, 149, 24'hFF0080, 8'hFF, 24'h123456));
		send_pixel(pixel_at(149, 149, 24'h00FF7F, 8'h80, 24'hFF00A5));
		send_pixel(pixel_at(0, 0, 24'hFFFFFF, 8'hFF, 24'hFFFFFF));
		send_pixel(pixel_at(1023, 1023, 24'hFFFFFF, 8'hFF, 24'hFFFFFF));
		send_pixel(pixel_at(295, 149, 24'hFFFFFF, 8'h00, 24'h000000));
		send_pixel(pixel_at(296, 149, 24'hFFFFFF, 8'h40, 24'hFFFFFF));
		send_pixel(pixel_at(4, 149, 24'hC0A050, 8'h40, 24'h30F010));
		send_pixel(pixel_at(149, 295, 24'h000000, 8'h01, 24'hFFFFFF));
		send_pixel(pixel_at(149, 4, 24'hFFFFFF, 8'hFE, 24'h000000));
	endtask

	task automatic test_register_map();
		// unused indexes leave both registers alone
		write_reg(REG_SPARE_2, '1);
		write_reg(REG_SPARE_3, '0);
		send_pixel(pixel_at(295, 149, 24'hFFFFFF, 8'h00, 24'h000000));
		// only the low bits of the data reach the border register
		write_reg(REG_BORDER_WIDTH, 10'h3E5);
		send_pixel(pixel_at(295, 149, 24'hFFFFFF, 8'h00, 24'h000000));
		set_lens(1023, 31);
		send_pixel(pixel_at(511, 511, 24'h5AA5FF, 8'h00, 24'h000000));
		send_pixel(pixel_at(1023, 511, 24'h5AA5FF, 8'h00, 24'h000000));
		set_lens(1023, 1);
		send_pixel(pixel_at(1021, 511, 24'hFFFFFF, 8'h00, 24'h000000));
		send_pixel(pixel_at(1021, 512, 24'hFFFFFF, 8'h00, 24'h000000));
		send_pixel(pixel_at(1022, 511, 24'hFFFFFF, 8'h00, 24'h000000));
	endtask

	task automatic test_ring_extremes();
		set_lens(1, 0);
		send_pixel(pixel_at(0, 0, 24'h804020, 8'h00, 24'h000000));
		set_lens(0, 0);
		send_pixel(pixel_at(0, 0, 24'hFFFFFF, 8'hFF, 24'hFFFFFF));
		// inner radius zero
		set_lens(8, 4);
		send_pixel(pixel_at(3, 3, 24'hFFFFFF, 8'h00, 24'h000000));
		send_pixel(pixel_at(4, 4, 24'hFFFFFF, 8'h00, 24'h000000));
		// ring wider than the lens
		set_lens(7, 4);
		send_pixel(pixel_at(3, 3, 24'hFFFFFF, 8'hFF, 24'hFFFFFF));
		set_lens(2, 0);
		send_pixel(pixel_at(0, 0, 24'hFFFFFF, 8'h00, 24'h000000));
		set_lens(3, 1);
		send_pixel(pixel_at(1, 1, 24'hFFFFFF, 8'h00, 24'h000000));
	endtask

	// receiver holds off long enough to fill the pipeline and stall the input
	task automatic test_input_stall();
		set_lens(300, 4);
		src_idle_on = 1'b0;
		sink_hold_req <= 1'b1;
		repeat (80) send_pixel(random_pixel());
		src_idle_on = 1'b1;
		repeat (20) send_pixel(random_pixel());
		wait_drained();
		repeat (20) send_pixel(random_pixel());
	endtask

	task automatic test_random_pixels();
		int d, b;
		for (int phase = 0; phase < 12; phase++) begin
			case (phase)
				0: begin d = 1000; b = 20; end
				1: begin d = 100; b = 1; end
				2: begin d = 1023; b = 0; end
				3: begin d = 64; b = 31; end
				default: begin
					d = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 1023)
						: $urandom_range(100, 1000);
					b = $urandom_range(0, 31);
				end
			endcase
			set_lens(d, b);
			if (phase == 11) begin
				// no idling on either side at the end
				src_idle_on = 1'b0;
				sink_idle_on <= 1'b0;
				repeat (150) send_pixel(random_pixel());
			end else begin
				src_idle_on = ($urandom_range(0, 3) != 0);
				repeat (90) send_pixel(random_pixel());
			end
		end
	endtask

	task automatic check_field(input string name, input logic [CH_W-1:0] want,
			input logic [CH_W-1:0] got);
		if (got !== want) begin
			mismatch_cnt++;
			$display("%0t %s expected %0d actual %0d", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin
		if (sink_stall_left != 0) begin
			res_if.ready <= 1'b0;
			sink_stall_left <= sink_stall_left - 1;
		end else if (sink_hold_req) begin
			res_if.ready <= 1'b0;
			sink_stall_left <= LONG_HOLD_CYCLES - 1;
			sink_hold_req <= 1'b0;
		end else if (sink_idle_on && $urandom_range(0, 7) == 0) begin
			res_if.ready <= 1'b0;
			sink_stall_left <= $urandom_range(0, 12);
		end else begin
			res_if.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		px_result_t want;
		if (arst_n && res_if.valid && res_if.ready) begin
			if (blend_expect_q.size() == 0) begin
				mismatch_cnt++;
				$display("%0t result expected none actual %0d %0d %0d %0d", $time,
					res_if.res_alpha, res_if.res_red, res_if.res_green,
					res_if.res_blue);
			end else begin
				want = blend_expect_q.pop_front();
				check_field("res_alpha", want.res_alpha, res_if.res_alpha);
				check_field("res_red", want.res_red, res_if.res_red);
				check_field("res_green", want.res_green, res_if.res_green);
				check_field("res_blue", want.res_blue, res_if.res_blue);
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		pix_if.valid = 1'b0;
		pix_if.pos_x = '0;
		pix_if.pos_y = '0;
		pix_if.cap_red = '0;
		pix_if.cap_green = '0;
		pix_if.cap_blue = '0;
		pix_if.ovl_alpha = '0;
		pix_if.ovl_red = '0;
		pix_if.ovl_green = '0;
		pix_if.ovl_blue = '0;
		cfg_if.valid = 1'b0;
		cfg_if.index = '0;
		cfg_if.data = '0;
		res_if.ready = 1'b0;
		lens_diam = DIAMETER_RESET;
		lens_border = BORDER_WIDTH_RESET;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_default_geometry();
		test_register_map();
		test_ring_extremes();
		test_input_stall();
		test_random_pixels();

		wait_drained();
		repeat (PIPE_DEPTH + 10) @(posedge clk);
		if (mismatch_cnt == 0 && blend_expect_q.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

[filelist.f]
+incdir+design
design/clmc_pkg.sv
design/clmc_if.sv
design/clmc_geom.sv
design/clmc_isqrt.sv
design/clmc_blend.sv
design/circular_lens_mask_compositor_core.sv
test/tb_circular_lens_mask_compositor_core.sv
